/* design/eprt_pkg.sv */
// ----------------------------------------------------------------------------
// eprt_pkg
// shared widths, fixed-point constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package eprt_pkg;

    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int ATAN_ENTRIES       = 24;

    // widths of the q30 datapath
    localparam int XW = 33;   // cosine / sine
    localparam int ZW = 34;   // residual angle
    localparam int PW = 67;   // q60 products and sums

    localparam int AW = 16;   // angle field
    localparam int TW = 32;   // translation field
    localparam int CW = 16;   // coefficient field

    typedef logic signed [XW-1:0] t_xy;
    typedef logic signed [ZW-1:0] t_z;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [AW-1:0] t_angle;
    typedef logic signed [TW-1:0] t_trans;
    typedef logic signed [CW-1:0] t_coef;

    typedef struct packed {
        t_trans x;
        t_trans y;
        t_trans z;
    } t_pos;

    localparam t_xy GAIN_Q30    = XW'(652032874);
    localparam t_z  PI_Q30      = ZW'(64'sd3373259426);
    localparam t_z  HALF_PI_Q30 = ZW'(64'sd1686629713);

    // floor(atan(2^-i) * 2^30)
    function automatic t_z atan_q30(input int idx);
        t_z v;
        case (idx)
            0:  v = ZW'(843314856);
            1:  v = ZW'(497837829);
            2:  v = ZW'(263043836);
            3:  v = ZW'(133525158);
            4:  v = ZW'(67021686);
            5:  v = ZW'(33543515);
            6:  v = ZW'(16775850);
            7:  v = ZW'(8388437);
            8:  v = ZW'(4194282);
            9:  v = ZW'(2097149);
            10: v = ZW'(1048575);
            11: v = ZW'(524287);
            12: v = ZW'(262143);
            13: v = ZW'(131071);
            14: v = ZW'(65535);
            15: v = ZW'(32767);
            16: v = ZW'(16383);
            17: v = ZW'(8191);
            18: v = ZW'(4095);
            19: v = ZW'(2047);
            20: v = ZW'(1023);
            21: v = ZW'(511);
            22: v = ZW'(255);
            23: v = ZW'(127);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/eprt_cordic.sv */
// ----------------------------------------------------------------------------
// eprt_cordic
// pipelined rotation-mode cordic: quadrant fold stage plus one stage per step
// ----------------------------------------------------------------------------
module eprt_cordic #(
    parameter int STEPS = 16
) (
    input  logic                  i_clk,
    input  logic [STEPS:0]        i_en,
    input  eprt_pkg::t_angle      i_angle,
    output eprt_pkg::t_xy         o_cos,
    output eprt_pkg::t_xy         o_sin
);
    import eprt_pkg::*;

    t_xy  r_x   [0:STEPS];
    t_xy  r_y   [0:STEPS];
    t_z   r_z   [0:STEPS];
    logic r_neg [0:STEPS-1];

    // fold angle into +-pi/2
    t_z   n_z0;
    logic n_neg0;
    t_z   w_ang;

    assign w_ang = t_z'({{(ZW-AW-17){i_angle[AW-1]}}, i_angle, 17'b0});

    always_comb begin
        n_z0   = w_ang;
        n_neg0 = 1'b0;
        if (w_ang > HALF_PI_Q30) begin
            n_z0   = w_ang - PI_Q30;
            n_neg0 = 1'b1;
        end else if (w_ang < -HALF_PI_Q30) begin
            n_z0   = w_ang + PI_Q30;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam t_z ATAN = atan_q30(k - 1);
        t_xy n_x;
        t_xy n_y;
        t_z  n_z;

        always_comb begin
            if (r_z[k-1] >= 0) begin
                n_x = r_x[k-1] - (r_y[k-1] >>> (k - 1));
                n_y = r_y[k-1] + (r_x[k-1] >>> (k - 1));
                n_z = r_z[k-1] - ATAN;
            end else begin
                n_x = r_x[k-1] + (r_y[k-1] >>> (k - 1));
                n_y = r_y[k-1] - (r_x[k-1] >>> (k - 1));
                n_z = r_z[k-1] + ATAN;
            end
        end

        if (k == STEPS) begin : g_last
            // undo the fold by negating both outputs
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_x[k] <= r_neg[k-1] ? -n_x : n_x;
                    r_y[k] <= r_neg[k-1] ? -n_y : n_y;
                    r_z[k] <= n_z;
                end
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_x[k]   <= n_x;
                    r_y[k]   <= n_y;
                    r_z[k]   <= n_z;
                    r_neg[k] <= r_neg[k-1];
                end
            end
        end
    end

    assign o_cos = r_x[STEPS];
    assign o_sin = r_y[STEPS];

endmodule

/* design/eprt_matrix.sv */
// ----------------------------------------------------------------------------
// eprt_matrix
// three-stage rotation matrix build: products, second products, sum and round
// ----------------------------------------------------------------------------
module eprt_matrix #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic           i_clk,
    input  logic [2:0]     i_en,
    input  eprt_pkg::t_xy  i_cx,
    input  eprt_pkg::t_xy  i_sx,
    input  eprt_pkg::t_xy  i_cy,
    input  eprt_pkg::t_xy  i_sy,
    input  eprt_pkg::t_xy  i_cz,
    input  eprt_pkg::t_xy  i_sz,
    output eprt_pkg::t_coef o_r00,
    output eprt_pkg::t_coef o_r01,
    output eprt_pkg::t_coef o_r02,
    output eprt_pkg::t_coef o_r10,
    output eprt_pkg::t_coef o_r11,
    output eprt_pkg::t_coef o_r12,
    output eprt_pkg::t_coef o_r20,
    output eprt_pkg::t_coef o_r21,
    output eprt_pkg::t_coef o_r22
);
    import eprt_pkg::*;

    localparam int    SH  = 60 - COEF_FRAC_BITS;
    localparam t_prod RND = t_prod'(1) <<< (SH - 1);
    localparam t_prod ONE = t_prod'(1) <<< COEF_FRAC_BITS;
    localparam t_prod Q30_HALF = t_prod'(1) <<< 29;

    function automatic t_coef finish(input t_prod v);
        t_prod r;
        r = (v + RND) >>> SH;
        if (r > ONE) begin
            r = ONE;
        end
        if (r < -ONE) begin
            r = -ONE;
        end
        return r[CW-1:0];
    endfunction

    // stage 1: first products
    t_prod r1_cycz, r1_cysz, r1_sxcy, r1_cxcy, r1_cxsz, r1_cxcz, r1_sxsz, r1_sxcz;
    t_z    r1_sxsy, r1_cxsy;
    t_xy   r1_sy, r1_cz, r1_sz;
    t_prod n_sxsy, n_cxsy;

    assign n_sxsy = ((t_prod'(i_sx) * t_prod'(i_sy)) + Q30_HALF) >>> 30;
    assign n_cxsy = ((t_prod'(i_cx) * t_prod'(i_sy)) + Q30_HALF) >>> 30;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_cycz <= t_prod'(i_cy) * t_prod'(i_cz);
            r1_cysz <= t_prod'(i_cy) * t_prod'(i_sz);
            r1_sxcy <= t_prod'(i_sx) * t_prod'(i_cy);
            r1_cxcy <= t_prod'(i_cx) * t_prod'(i_cy);
            r1_cxsz <= t_prod'(i_cx) * t_prod'(i_sz);
            r1_cxcz <= t_prod'(i_cx) * t_prod'(i_cz);
            r1_sxsz <= t_prod'(i_sx) * t_prod'(i_sz);
            r1_sxcz <= t_prod'(i_sx) * t_prod'(i_cz);
            r1_sxsy <= n_sxsy[ZW-1:0];
            r1_cxsy <= n_cxsy[ZW-1:0];
            r1_sy   <= i_sy;
            r1_cz   <= i_cz;
            r1_sz   <= i_sz;
        end
    end

    // stage 2: products with the q30 intermediates
    t_prod r2_cycz, r2_cysz, r2_sxcy, r2_cxcy, r2_cxsz, r2_cxcz, r2_sxsz, r2_sxcz;
    t_prod r2_sxsycz, r2_sxsysz, r2_cxsycz, r2_cxsysz, r2_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_cycz   <= r1_cycz;
            r2_cysz   <= r1_cysz;
            r2_sxcy   <= r1_sxcy;
            r2_cxcy   <= r1_cxcy;
            r2_cxsz   <= r1_cxsz;
            r2_cxcz   <= r1_cxcz;
            r2_sxsz   <= r1_sxsz;
            r2_sxcz   <= r1_sxcz;
            r2_sxsycz <= t_prod'(r1_sxsy) * t_prod'(r1_cz);
            r2_sxsysz <= t_prod'(r1_sxsy) * t_prod'(r1_sz);
            r2_cxsycz <= t_prod'(r1_cxsy) * t_prod'(r1_cz);
            r2_cxsysz <= t_prod'(r1_cxsy) * t_prod'(r1_sz);
            r2_sy     <= t_prod'(r1_sy) <<< 30;
        end
    end

    // stage 3: sums, rounding and saturation
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_r00 <= finish(r2_cycz);
            o_r01 <= finish(-r2_cysz);
            o_r02 <= finish(r2_sy);
            o_r10 <= finish(r2_cxsz + r2_sxsycz);
            o_r11 <= finish(r2_cxcz - r2_sxsysz);
            o_r12 <= finish(-r2_sxcy);
            o_r20 <= finish(r2_sxsz - r2_cxsycz);
            o_r21 <= finish(r2_cxsysz + r2_sxcz);
            o_r22 <= finish(r2_cxcy);
        end
    end

endmodule

/* design/euler_pose_to_rigid_transform.sv */
// ----------------------------------------------------------------------------
// euler_pose_to_rigid_transform
// pose (translation, roll, pitch, yaw) to 3x4 rigid transform [R | t]
// ----------------------------------------------------------------------------
// usage:
//   input channel: i_valid / o_stall carry one pose request (q16.16 translation,
//   q3.13 radian angles); a request is taken on a clock edge with i_valid high
//   and o_stall low
//   output channel: o_valid / i_stall carry the twelve transform fields
//   (q2.14 rotation entries, translation passed through unchanged)
// stages: one angle fold stage, one stage per cordic step, three matrix stages
// throughput: one pose per cycle while o_stall is low; the three angles run
//   through parallel cordic lanes and every stage is registered
// stall: each stage moves when it is empty or the stage after it moves, so a
//   stalled output holds its result while bubbles in the pipe still fill;
//   o_stall rises only once every stage holds a pose
// reset: clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
module euler_pose_to_rigid_transform #(
    parameter int CORDIC_STEPS   = eprt_pkg::CORDIC_STEPS_DEF,
    parameter int COEF_FRAC_BITS = eprt_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  eprt_pkg::t_trans  i_pos_x,
    input  eprt_pkg::t_trans  i_pos_y,
    input  eprt_pkg::t_trans  i_pos_z,
    input  eprt_pkg::t_angle  i_roll_angle,
    input  eprt_pkg::t_angle  i_pitch_angle,
    input  eprt_pkg::t_angle  i_yaw_angle,
    output logic              o_valid,
    input  logic              i_stall,
    output eprt_pkg::t_coef   o_r00,
    output eprt_pkg::t_coef   o_r01,
    output eprt_pkg::t_coef   o_r02,
    output eprt_pkg::t_trans  o_trans_x,
    output eprt_pkg::t_coef   o_r10,
    output eprt_pkg::t_coef   o_r11,
    output eprt_pkg::t_coef   o_r12,
    output eprt_pkg::t_trans  o_trans_y,
    output eprt_pkg::t_coef   o_r20,
    output eprt_pkg::t_coef   o_r21,
    output eprt_pkg::t_coef   o_r22,
    output eprt_pkg::t_trans  o_trans_z
);
    import eprt_pkg::*;

    // total stages: fold + cordic steps + three matrix stages
    localparam int CS = CORDIC_STEPS + 1;
    localparam int L  = CS + 3;

    logic [L-1:0] r_vld;
    logic [L-1:0] w_en;

    // stage k may load when it is empty or its content moves on
    assign w_en[L-1] = !r_vld[L-1] || !i_stall;
    for (genvar k = 0; k < L - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < L; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[L-1];

    // translation rides alongside the rotation pipe
    t_pos r_pos [0:L-1];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pos[0] <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        for (int k = 1; k < L; k++) begin
            if (w_en[k]) begin
                r_pos[k] <= r_pos[k-1];
            end
        end
    end

    assign o_trans_x = r_pos[L-1].x;
    assign o_trans_y = r_pos[L-1].y;
    assign o_trans_z = r_pos[L-1].z;

    // one cordic lane per angle
    t_xy w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;

    eprt_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en[CS-1:0]),
        .i_angle (i_roll_angle),
        .o_cos   (w_cx),
        .o_sin   (w_sx)
    );

    eprt_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en[CS-1:0]),
        .i_angle (i_pitch_angle),
        .o_cos   (w_cy),
        .o_sin   (w_sy)
    );

    eprt_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en[CS-1:0]),
        .i_angle (i_yaw_angle),
        .o_cos   (w_cz),
        .o_sin   (w_sz)
    );

    // products, sums and rounding to the output format
    eprt_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
        .i_clk (i_clk),
        .i_en  (w_en[L-1:CS]),
        .i_cx  (w_cx),
        .i_sx  (w_sx),
        .i_cy  (w_cy),
        .i_sy  (w_sy),
        .i_cz  (w_cz),
        .i_sz  (w_sz),
        .o_r00 (o_r00),
        .o_r01 (o_r01),
        .o_r02 (o_r02),
        .o_r10 (o_r10),
        .o_r11 (o_r11),
        .o_r12 (o_r12),
        .o_r20 (o_r20),
        .o_r21 (o_r21),
        .o_r22 (o_r22)
    );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks euler_pose_to_rigid_transform against a cordic-based pose model;
// poses are queued by a stimulus block, driven through valid/stall with
// random idling and stalling, and every transform is compared field by field
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eprt_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int FRAC  = COEF_FRAC_BITS_DEF;
    localparam int PIPE_DEPTH = STEPS + 4;

    typedef struct {
        t_trans px, py, pz;
        t_angle roll, pitch, yaw;
    } t_pose;

    typedef struct {
        t_coef  r[9];
        t_trans tx, ty, tz;
    } t_xform;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_trans i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    t_angle i_roll_angle = '0, i_pitch_angle = '0, i_yaw_angle = '0;
    logic o_stall, o_valid;
    t_coef o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    t_trans o_trans_x, o_trans_y, o_trans_z;

    euler_pose_to_rigid_transform uut (.*);

    always #5 i_clk = ~i_clk;

    t_pose  pending_poses[$];
    t_xform expected_xforms[$];
    int     mismatch_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     stim_done = 1'b0;

    // ------------------------------------------------------------------
    // pose model
    // ------------------------------------------------------------------
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;   // arithmetic shift on signed longint
    endfunction

    function automatic void cordic_sincos(t_angle ang, output longint c,
                                          output longint s);
        longint z, x, y, t;
        bit     flip;
        z = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > longint'(HALF_PI_Q30)) begin
            z -= longint'(PI_Q30);
            flip = 1'b1;
        end else if (z < -longint'(HALF_PI_Q30)) begin
            z += longint'(PI_Q30);
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
            if (z >= 0) begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= longint'(atan_q30(i));
            end else begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += longint'(atan_q30(i));
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // q60 to q2.14 coefficient with round-to-nearest and saturation
    function automatic t_coef to_coef(longint v);
        longint r, one;
        int sh;
        sh = 60 - FRAC;
        one = longint'(1) << FRAC;
        r = (v + (longint'(1) << (sh - 1))) >>> sh;
        if (r > one) r = one;
        if (r < -one) r = -one;
        return t_coef'(r);
    endfunction

    function automatic t_xform pose_to_xform(t_pose p);
        t_xform e;
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        cordic_sincos(p.roll, cx, sx);
        cordic_sincos(p.pitch, cy, sy);
        cordic_sincos(p.yaw, cz, sz);
        sxsy = (sx * sy + (longint'(1) << 29)) >>> 30;
        cxsy = (cx * sy + (longint'(1) << 29)) >>> 30;
        e.r[0] = to_coef(cy * cz);
        e.r[1] = to_coef(-(cy * sz));
        e.r[2] = to_coef(sy * (longint'(1) << 30));
        e.r[3] = to_coef(cx * sz + sxsy * cz);
        e.r[4] = to_coef(cx * cz - sxsy * sz);
        e.r[5] = to_coef(-(sx * cy));
        e.r[6] = to_coef(sx * sz - cxsy * cz);
        e.r[7] = to_coef(cxsy * sz + sx * cz);
        e.r[8] = to_coef(cx * cy);
        e.tx = p.px;
        e.ty = p.py;
        e.tz = p.pz;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // driver: new request presented when the current one is taken or none
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pose p;
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_poses.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    p = pending_poses.pop_front();
                    i_valid <= 1'b1;
                    i_pos_x <= p.px;
                    i_pos_y <= p.py;
                    i_pos_z <= p.pz;
                    i_roll_angle <= p.roll;
                    i_pitch_angle <= p.pitch;
                    i_yaw_angle <= p.yaw;
                    expected_xforms.insert(expected_xforms.size(), pose_to_xform(p));
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // monitor: compare each accepted transform with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_xform e;
        t_coef  got[9];
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_xforms.size() == 0) begin
                report_mismatch("unexpected transform", 1, 0);
            end else begin
                e = expected_xforms.pop_front();
                got = '{o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22};
                for (int k = 0; k < 9; k++)
                    if (got[k] !== e.r[k])
                        report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), got[k], e.r[k]);
                if (o_trans_x !== e.tx) report_mismatch("trans_x", o_trans_x, e.tx);
                if (o_trans_y !== e.ty) report_mismatch("trans_y", o_trans_y, e.ty);
                if (o_trans_z !== e.tz) report_mismatch("trans_z", o_trans_z, e.tz);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic t_angle pick_angle();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return t_angle'($urandom);               // any pattern, beyond pi too
        if (sel == 1) return t_angle'($urandom_range(12860, 12876));  // near pi/2
        if (sel == 2) return -t_angle'($urandom_range(12860, 12876));
        return t_angle'(int'($urandom_range(51472)) - 25736);
    endfunction

    function automatic t_trans pick_trans();
        case ($urandom_range(4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return t_trans'($urandom);
        endcase
    endfunction

    task automatic add_pose(t_trans x, t_trans y, t_trans z,
                            t_angle r, t_angle p, t_angle w);
        t_pose q;
        q.px = x; q.py = y; q.pz = z;
        q.roll = r; q.pitch = p; q.yaw = w;
        pending_poses.insert(pending_poses.size(), q);
    endtask

    task automatic drain();
        while (pending_poses.size() > 0 || expected_xforms.size() > 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        t_angle corner[9];
        corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                   16'sd12869, -16'sd12869, 16'sh7fff, 16'sh8000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero pose, extreme translations, angles at 0, +-pi/2, +-pi
        // and the raw extremes of the angle field
        add_pose(0, 0, 0, 0, 0, 0);
        add_pose(32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0);
        add_pose(32'sh80000000, 32'sh7fffffff, 32'sh55555555, 0, 0, 0);
        foreach (corner[k]) begin
            add_pose(k, -k, 32'shaaaaaaaa, corner[k], 0, 0);
            add_pose(k, -k, 32'sh12345678, 0, corner[k], corner[(k + 3) % 9]);
        end
        add_pose(1, 2, 3, 16'sh7fff, 16'sh8000, 16'sh7fff);
        add_pose(4, 5, 6, 16'sh8000, 16'sh7fff, 16'sh8000);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                3: begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (290)
                add_pose(pick_trans(), pick_trans(), pick_trans(),
                         pick_angle(), pick_angle(), pick_angle());
            drain();
        end
        repeat (PIPE_DEPTH * 2) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------
    initial begin
        wait (stim_done);
        if (mismatch_count == 0 && expected_xforms.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/eprt_pkg.sv
design/eprt_cordic.sv
design/eprt_matrix.sv
design/euler_pose_to_rigid_transform.sv
sim/tb.sv
